>>> sv/dppm_pkg.sv
// Package for the distance move controller: opcodes, register indexes,
// reset values, shared multiplier widths and request type, saturation helper.
// No dependencies.
package dppm_pkg;

	localparam int RAMP_STEPS_DEF = 20;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CM_PER_PULSE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_MIN      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd6;

	localparam logic signed [15:0] GAIN_P_RST    = 16'sd1280;
	localparam logic signed [15:0] GAIN_I_RST    = 16'sd26;
	localparam logic signed [15:0] GAIN_D_RST    = 16'sd512;
	localparam logic signed [15:0] SPEED_MAX_RST = 16'sd1024;
	localparam logic signed [15:0] SPEED_MIN_RST = -16'sd1024;
	localparam logic [30:0]        INT_LIMIT_RST = 31'd6553600;

	localparam int DEADBAND_Q8 = 128;
	localparam int WINDOW_Q16  = 32768;

	// shared multiplier: signed A x signed B, registered product
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W - 1;

	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

>>> sv/distance_position_pid_move.sv
// Distance move controller: odometry, position PID, deadband and end ramp.
// Every multiply goes through one shared multiplier (dppm_mul) under a sequencer.
// Depends on dppm_pkg and dppm_mul.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one control tick per beat: op,
//   left_pulses, right_pulses and move_distance. Output channel
//   (out_valid/out_stall) returns one beat per input beat with speed_target,
//   move_done, moving, position_error and average_distance.
//   Configuration is a plain write port (cfg_we, cfg_idx, cfg_data), to be
//   written while the block is idle; the user must keep to this, the block does not enforce it.
//   A start, stop or idle tick runs the odometry and op steps only; a PID
//   tick adds the PID steps, and a PID tick in the end window that scales
//   the speed adds the ramp steps. All multiplies share the one multiplier,
//   one product a cycle. One beat is in work at a time and in_stall is high
//   until its result is registered, so a beat is taken only once the last one is through.
//   A finished beat sits in the output register while the next one is taken;
//   if the receiver stalls, the sequencer waits at its last step and the beat holds.
//   Reset clears odometry, PID state and output valid, reloads the ramp
//   counter and sets the registers to their default values.
module distance_position_pid_move import dppm_pkg::*; #(
	parameter int RAMP_STEPS = RAMP_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            op,
	input  logic signed [15:0]    left_pulses,
	input  logic signed [15:0]    right_pulses,
	input  logic signed [31:0]    move_distance,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [15:0]    speed_target,
	output logic                  move_done,
	output logic                  moving,
	output logic signed [31:0]    position_error,
	output logic signed [31:0]    average_distance,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int RAMP_W = $clog2(RAMP_STEPS + 1);
	// reciprocal for the ramp division: exact for dividends below 2^DIV_N
	localparam int DIV_N = 15 + RAMP_W;
	localparam int DIV_S = DIV_N + $clog2(RAMP_STEPS);
	localparam longint unsigned DIV_M =
		((64'd1 << DIV_S) + 64'(RAMP_STEPS) - 64'd1) / 64'(RAMP_STEPS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_ODO_L, ST_ODO_R, ST_AVG, ST_OP, ST_ERR, ST_MUL_I, ST_MUL_D,
		ST_ACC_D, ST_CLAMP, ST_RAMP_M, ST_RAMP_D, ST_RAMP_Q, ST_OUT
	} state_t;

	state_t state_q;

	logic [15:0]        cm_q;
	logic signed [15:0] gp_q, gi_q, gd_q, smax_q, smin_q;
	logic [30:0]        lim_q;

	logic [1:0]         op_q;
	logic signed [15:0] lp_q, rp_q;
	logic signed [31:0] dist_q;

	logic signed [31:0] left_q, right_q, goal_q, sum_q, prior_q, err_q;
	logic signed [15:0] speed_q;
	logic               active_q;
	logic [RAMP_W-1:0]  ramp_q;
	logic signed [MUL_P_W-1:0] acc_q;

	logic               out_valid_q;
	logic signed [15:0] out_speed_q;
	logic               out_moving_q;
	logic signed [31:0] out_err_q, out_avg_q;

	mul_req_t                  req;
	logic signed [MUL_P_W-1:0] prod;

	dppm_mul u_mul (
		.clk     (clk),
		.req     (req),
		.prod_s1 (prod)
	);

	logic signed [32:0] tsum, avg_ext, raw, sum_next, lim33;
	logic signed [31:0] avg, e_now;
	logic signed [MUL_P_W-1:0] sh, o1, o2, smax_ext, smin_ext;
	logic signed [15:0] o_pid;
	logic               in_win;
	logic signed [23:0] rx, rx_abs;
	logic [MUL_P_W-1:0] qwide;
	logic [15:0]        q;

	always_comb begin
		tsum     = 33'(left_q) + 33'(right_q);
		avg_ext  = tsum >>> 1;
		avg      = avg_ext[31:0];
		raw      = 33'(goal_q) - 33'(avg);
		e_now    = sat32(64'(raw));
		in_win   = (raw > -33'sd32768) && (raw < 33'sd32768);
		lim33    = $signed({2'b00, lim_q});
		sum_next = 33'(sum_q) + 33'(e_now);
		if (sum_next > lim33) begin
			sum_next = lim33;
		end
		if (sum_next < -lim33) begin
			sum_next = -lim33;
		end
		sh       = acc_q >>> 16;
		smax_ext = MUL_P_W'(smax_q);
		smin_ext = MUL_P_W'(smin_q);
		o1       = (sh > smax_ext) ? smax_ext : sh;
		o2       = (o1 < smin_ext) ? smin_ext : o1;
		if ((o2 > -MUL_P_W'(DEADBAND_Q8)) && (o2 < MUL_P_W'(DEADBAND_Q8))) begin
			o_pid = '0;
		end else begin
			o_pid = o2[15:0];
		end
		rx     = prod[23:0];
		rx_abs = rx[23] ? -rx : rx;
		qwide  = prod >> DIV_S;
		q      = qwide[15:0];
	end

	always_comb begin
		req.en = 1'b1;
		req.a  = '0;
		req.b  = '0;
		case (state_q)
			ST_ODO_L: begin
				req.a = MUL_A_W'(lp_q);
				req.b = $signed(MUL_B_W'(cm_q));
			end
			ST_ODO_R: begin
				req.a = MUL_A_W'(rp_q);
				req.b = $signed(MUL_B_W'(cm_q));
			end
			ST_ERR: begin
				req.a = MUL_A_W'(e_now);
				req.b = MUL_B_W'(gp_q);
			end
			ST_MUL_I: begin
				req.a = MUL_A_W'(sum_q);
				req.b = MUL_B_W'(gi_q);
			end
			ST_MUL_D: begin
				req.a = MUL_A_W'(err_q) - MUL_A_W'(prior_q);
				req.b = MUL_B_W'(gd_q);
			end
			ST_RAMP_M: begin
				req.a = MUL_A_W'(speed_q);
				req.b = $signed(MUL_B_W'(ramp_q));
			end
			ST_RAMP_D: begin
				req.a = $signed(MUL_A_W'(DIV_M));
				req.b = rx_abs;
			end
			default: begin
				req.en = 1'b0;
			end
		endcase
	end

	logic neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cm_q         <= '0;
			gp_q         <= GAIN_P_RST;
			gi_q         <= GAIN_I_RST;
			gd_q         <= GAIN_D_RST;
			smax_q       <= SPEED_MAX_RST;
			smin_q       <= SPEED_MIN_RST;
			lim_q        <= INT_LIMIT_RST;
			op_q         <= '0;
			lp_q         <= '0;
			rp_q         <= '0;
			dist_q       <= '0;
			left_q       <= '0;
			right_q      <= '0;
			goal_q       <= '0;
			sum_q        <= '0;
			prior_q      <= '0;
			err_q        <= '0;
			speed_q      <= '0;
			active_q     <= 1'b0;
			ramp_q       <= RAMP_W'(RAMP_STEPS);
			acc_q        <= '0;
			neg_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_speed_q  <= '0;
			out_moving_q <= 1'b0;
			out_err_q    <= '0;
			out_avg_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_CM_PER_PULSE:   cm_q   <= cfg_data[15:0];
					REG_GAIN_P:         gp_q   <= $signed(cfg_data[15:0]);
					REG_GAIN_I:         gi_q   <= $signed(cfg_data[15:0]);
					REG_GAIN_D:         gd_q   <= $signed(cfg_data[15:0]);
					REG_SPEED_MAX:      smax_q <= $signed(cfg_data[15:0]);
					REG_SPEED_MIN:      smin_q <= $signed(cfg_data[15:0]);
					REG_INTEGRAL_LIMIT: lim_q  <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= op;
						lp_q    <= left_pulses;
						rp_q    <= right_pulses;
						dist_q  <= move_distance;
						state_q <= ST_ODO_L;
					end
				end
				ST_ODO_L: state_q <= ST_ODO_R;
				ST_ODO_R: begin
					left_q  <= sat32(64'(left_q) + 64'(prod));
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					right_q <= sat32(64'(right_q) + 64'(prod));
					state_q <= ST_OP;
				end
				ST_OP: begin
					state_q <= ST_OUT;
					case (op_q)
						OP_START: begin
							if (!active_q) begin
								active_q <= 1'b1;
								goal_q   <= sat32(64'(avg) + 64'(dist_q));
								err_q    <= '0;
								prior_q  <= '0;
								sum_q    <= '0;
								speed_q  <= '0;
								ramp_q   <= RAMP_W'(RAMP_STEPS);
							end
						end
						OP_STOP: begin
							active_q <= 1'b0;
							speed_q  <= '0;
							sum_q    <= '0;
						end
						default: begin
							if (active_q) begin
								state_q <= ST_ERR;
							end
						end
					endcase
				end
				ST_ERR: begin
					err_q <= e_now;
					if (gi_q != '0) begin
						sum_q <= sum_next[31:0];
					end
					state_q <= ST_MUL_I;
				end
				ST_MUL_I: begin
					acc_q   <= prod;
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: begin
					acc_q   <= acc_q + prod;
					state_q <= ST_ACC_D;
				end
				ST_ACC_D: begin
					acc_q   <= acc_q + prod;
					prior_q <= err_q;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					speed_q <= o_pid;
					state_q <= ST_OUT;
					if (in_win) begin
						if (ramp_q != '0) begin
							ramp_q  <= ramp_q - RAMP_W'(1);
							state_q <= ST_RAMP_M;
						end else begin
							active_q <= 1'b0;
							speed_q  <= '0;
							sum_q    <= '0;
						end
					end
				end
				ST_RAMP_M: state_q <= ST_RAMP_D;
				ST_RAMP_D: begin
					neg_q   <= rx[23];
					state_q <= ST_RAMP_Q;
				end
				ST_RAMP_Q: begin
					speed_q <= neg_q ? -$signed(q) : $signed(q);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_speed_q  <= speed_q;
						out_moving_q <= active_q;
						out_err_q    <= err_q;
						out_avg_q    <= avg;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall         = (state_q != ST_IDLE);
	assign out_valid        = out_valid_q;
	assign speed_target     = out_speed_q;
	assign moving           = out_moving_q;
	assign move_done        = !out_moving_q;
	assign position_error   = out_err_q;
	assign average_distance = out_avg_q;

endmodule

>>> sv/dppm_mul.sv
// Shared signed multiplier with a registered product.
// Depends on dppm_pkg (widths, request struct).
module dppm_mul import dppm_pkg::*; (
	input  logic                      clk,
	input  mul_req_t                  req,
	output logic signed [MUL_P_W-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_s1 <= MUL_P_W'($signed(req.a)) * MUL_P_W'($signed(req.b));
		end
	end

endmodule

>>> sv/dppm_chk.sv
// Port-level checker for distance_position_pid_move, bound to the top level.
// No package dependency.
module dppm_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] speed_target,
	input logic               move_done,
	input logic               moving,
	input logic signed [31:0] position_error,
	input logic signed [31:0] average_distance
);

	a_done_vs_moving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (move_done != moving))
		else $error("move_done and moving disagree");

	a_idle_speed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !moving) |-> (speed_target == 16'sd0))
		else $error("speed target nonzero with no move running");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(speed_target)
			&& $stable(moving) && $stable(position_error)
			&& $stable(average_distance)))
		else $error("stalled output beat changed");

endmodule

bind distance_position_pid_move dppm_chk u_dppm_chk (.*);
